// File: rtl/sis_pkg.sv
// Shared types and constants for the sorted integer set.
`timescale 1ns / 1ps
`default_nettype none
package sis_pkg;

  localparam int VALUE_W = 32;
  localparam int KIND_W  = 2;
  localparam int COUNT_OUT_W = 5;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Request codes carried on the input tuser; code 3 is ignored.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_LOOKUP = 2'd2
  } kind_t;

  // Per-cell update command for the apply cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } st_t;

endpackage
`default_nettype wire

// File: rtl/sis_cell.sv
// One storage cell of the sorted chain: holds an entry, compares, and shifts.
`timescale 1ns / 1ps
`default_nettype none
module sis_cell (
  input  logic                clk,
  input  logic                cmp_en,
  input  sis_pkg::value_t     cmp_value,
  input  logic                valid,
  input  sis_pkg::cell_ctrl_t ctrl,
  input  sis_pkg::value_t     req_value,
  input  logic                prev_lt,
  input  sis_pkg::value_t     left_value,
  input  sis_pkg::value_t     right_value,
  output sis_pkg::value_t     value,
  output logic                lt,
  output logic                eq
);
  import sis_pkg::*;

  // Compare the incoming request value against this entry.
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt <= valid && (value < cmp_value);
      eq <= valid && (value == cmp_value);
    end
  end

  // Entries below the insertion point stay; the others move by one place.
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      value <= prev_lt ? req_value : left_value;
    end else if (ctrl.rem && !lt) begin
      value <= right_value;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sorted_integer_set.sv
// Top level of the sorted integer set: request handling, cell chain and result register.
//
// Usage:
//   Requests arrive on the s_ group: s_tuser carries the kind (insert, remove,
//   lookup; code 3 is ignored) and s_tdata the signed 32-bit value. Each
//   request yields exactly one result on the m_ group: success, overflow and
//   the number of held values (modulo 32).
//   At the accept edge every cell of the chain compares its entry with the
//   value in parallel and stores the outcome; at the apply edge, once the
//   result register is free, the chain shifts by one place where needed and
//   the result is registered, raising m_tvalid. A new request is accepted
//   only after the previous one has been applied, set by this compare-then-
//   shift pass through the cell chain.
//   The result register decouples the output: s_tready returns while a
//   result waits. If a second result is ready before the first is taken, the
//   chain holds its update until m_tready frees the register.
//   Reset clears the count and the handshake state; the set is then empty.
`timescale 1ns / 1ps
`default_nettype none
module sorted_integer_set #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] success, [1] overflow, [6:2] element_count, [7] zero
);
  import sis_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  st_t state, state_next;
  logic accept, apply_go;

  kind_t  req_kind;
  value_t req_value;
  logic [CW-1:0] count, count_next;

  logic [CAPACITY-1:0] valid_vec, lt_vec, eq_vec;
  value_t cell_value [CAPACITY];
  cell_ctrl_t ctrl;

  logic present, full, success_next, overflow_next;
  logic out_success, out_overflow;
  logic [COUNT_OUT_W-1:0] out_count;

  assign accept = s_tvalid && s_tready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: apply only once the result register is free.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    apply_go   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!m_tvalid || m_tready) begin
          apply_go   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture the request.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind  <= kind_t'(s_tuser);
      req_value <= value_t'(s_tdata);
    end
  end

  // Decide the outcome from the stored compare flags.
  assign present = |eq_vec;
  assign full    = (count == CW'(CAPACITY));

  always_comb begin
    ctrl          = '0;
    success_next  = 1'b0;
    overflow_next = 1'b0;
    count_next    = count;
    case (req_kind)
      KIND_INSERT: begin
        if (!present) begin
          if (full) begin
            overflow_next = 1'b1;
          end else begin
            ctrl.ins     = apply_go;
            success_next = 1'b1;
            count_next   = count + CW'(1);
          end
        end
      end
      KIND_REMOVE: begin
        if (present) begin
          ctrl.rem     = apply_go;
          success_next = 1'b1;
          count_next   = count - CW'(1);
        end
      end
      KIND_LOOKUP: success_next = present;
      default: ;
    endcase
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_go) begin
      count <= count_next;
    end
  end

  // Cell chain: each cell sees its neighbors' entries and the left compare flag.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic   prev_lt_w;
    value_t left_w, right_w;

    assign valid_vec[gi] = (count > CW'(gi));

    if (gi == 0) begin : g_first
      assign prev_lt_w = 1'b1;
      assign left_w    = cell_value[gi];
    end else begin : g_mid_l
      assign prev_lt_w = lt_vec[gi-1];
      assign left_w    = cell_value[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign right_w = cell_value[gi];
    end else begin : g_mid_r
      assign right_w = cell_value[gi+1];
    end

    sis_cell u_cell (
      .clk         (clk),
      .cmp_en      (accept),
      .cmp_value   (value_t'(s_tdata)),
      .valid       (valid_vec[gi]),
      .ctrl        (ctrl),
      .req_value   (req_value),
      .prev_lt     (prev_lt_w),
      .left_value  (left_w),
      .right_value (right_w),
      .value       (cell_value[gi]),
      .lt          (lt_vec[gi]),
      .eq          (eq_vec[gi])
    );
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (apply_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_success  <= success_next;
      out_overflow <= overflow_next;
      out_count    <= COUNT_OUT_W'(count_next);
    end
  end

  assign m_tdata = {1'b0, out_count, out_overflow, out_success};

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("held count exceeds capacity");

  // Entries below the value form a contiguous run from cell zero.
  a_lt_thermo: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> (((lt_vec + CAPACITY'(1)) & lt_vec) == '0))
    else $error("less-than flags are not a prefix");

  // At most one cell can match a value.
  a_eq_single: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> $onehot0(eq_vec))
    else $error("duplicate entries in the set");

  // An applied request always leaves a result waiting.
  a_apply_result: assert property (@(posedge clk) disable iff (rst)
    apply_go |=> m_tvalid)
    else $error("applied request produced no result");

  // Overflow is never reported together with success.
  a_ovf_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_overflow && out_success))
    else $error("overflow with success");

  // The count only moves when a request is applied.
  a_count_move: assert property (@(posedge clk) disable iff (rst)
    !apply_go |=> $stable(count))
    else $error("count changed without an applied request");

endmodule
`default_nettype wire

// File: tb/sorted_integer_set_check.sv
// Checker for the sorted integer set: watches both streams, predicts and compares results.
`timescale 1ns / 1ps
module sorted_integer_set_check #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [0] success, [1] overflow, [6:2] element_count, [7] zero
  output int          fail_count,
  output int          outstanding
);
  import sis_pkg::*;

  typedef struct packed {
    logic                   ok;
    logic                   ovf;
    logic [COUNT_OUT_W-1:0] cnt;
  } set_outcome_t;

  // Shadow copy of the ordered store and the outcomes still owed by the block.
  value_t       shadow_vals[CAPACITY];
  int           shadow_count = 0;
  set_outcome_t due_outcomes[$];
  int           mismatches = 0;
  int           waiting = 0;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  // Apply one request to the shadow store and return the outcome it must produce.
  function automatic set_outcome_t apply_request(input logic [KIND_W-1:0] kind,
                                                 input value_t v);
    set_outcome_t res;
    int           slot;
    bit           found;
    res  = '0;
    slot = 0;
    while (slot < shadow_count && shadow_vals[slot] < v) slot++;
    found = (slot < shadow_count) && (shadow_vals[slot] == v);
    case (kind)
      KIND_INSERT: begin
        if (!found) begin
          if (shadow_count >= CAPACITY) begin
            res.ovf = 1'b1;
          end else begin
            for (int i = shadow_count; i > slot; i--) shadow_vals[i] = shadow_vals[i-1];
            shadow_vals[slot] = v;
            shadow_count++;
            res.ok = 1'b1;
          end
        end
      end
      KIND_REMOVE: begin
        if (found) begin
          for (int i = slot; i < shadow_count - 1; i++) shadow_vals[i] = shadow_vals[i+1];
          shadow_count--;
          res.ok = 1'b1;
        end
      end
      KIND_LOOKUP: res.ok = found;
      default: ;
    endcase
    res.cnt = COUNT_OUT_W'(shadow_count);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: result mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // Results are matched before requests: a result never belongs to a request
  // accepted at the same edge.
  always @(posedge clk) begin : watch
    set_outcome_t want;
    if (rst) begin
      shadow_count = 0;
      due_outcomes.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_outcomes.size() == 0) begin
          report_mismatch("unrequested result", int'(m_tdata), 0);
        end else begin
          want = due_outcomes.pop_front();
          if (m_tdata[0] !== want.ok) begin
            report_mismatch("success", int'(m_tdata[0]), int'(want.ok));
          end
          if (m_tdata[1] !== want.ovf) begin
            report_mismatch("overflow", int'(m_tdata[1]), int'(want.ovf));
          end
          if (m_tdata[6:2] !== want.cnt) begin
            report_mismatch("element_count", int'(m_tdata[6:2]), int'(want.cnt));
          end
          if (m_tdata[7] !== 1'b0) report_mismatch("padding bit", int'(m_tdata[7]), 0);
        end
      end
      if (s_tvalid && s_tready) begin
        due_outcomes.push_back(apply_request(s_tuser, s_tdata));
      end
    end
    waiting <= due_outcomes.size();
  end

endmodule

// File: tb/sorted_integer_set_test.sv
// Top of the sorted integer set testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps
module sorted_integer_set_test;
  import sis_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int HOLD_OFF    = 90;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 155;
  localparam int POOL_MAX    = 64;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
  localparam value_t VAL_MIN = value_t'(32'h8000_0000);
  localparam value_t VAL_MAX = value_t'(32'h7fff_ffff);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  int          fail_count;
  int          outstanding;

  // Traffic shaping shared between the request and result sides.
  logic   idle_on = 1'b0;
  bit     sender_idles = 1'b0;
  int     squeeze_ask = 0;
  value_t pool[POOL_MAX];
  int     pool_size = 1;
  int     cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sorted_integer_set #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  sorted_integer_set_check #(
    .CAPACITY(CAPACITY)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // A cluster of nearby or spread values so that duplicates and hits are common.
  function automatic void refill_pool();
    value_t base;
    value_t stride;
    base = $urandom;
    stride = ($urandom_range(0, 2) != 0) ? value_t'($urandom_range(1, 3)) : value_t'($urandom);
    pool_size = $urandom_range(6, 40);
    for (int i = 0; i < POOL_MAX; i++) pool[i] = base + i * stride;
  endfunction

  function automatic value_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return pool[$urandom_range(0, pool_size - 1)];
    if (r < 95) return value_t'($urandom);
    case ($urandom_range(0, 3))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return KIND_IGNORED;
    if (r < 3 + ins_pct) return KIND_INSERT;
    if (r < 3 + ins_pct + (97 - ins_pct) / 2) return KIND_REMOVE;
    return KIND_LOOKUP;
  endfunction

  // Offer one request and return at the edge where it is taken.
  task automatic drive_request(input logic [KIND_W-1:0] kind, input value_t v);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    n = sender_idles ? gap_length() : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= KIND_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop offering until every owed result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Result side: random stalls, a long hold-off on request, or always ready.
  initial begin
    int seen;
    int n;
    seen = 0;
    while (rst) @(posedge clk);
    forever begin
      if (squeeze_ask != seen) begin
        seen = squeeze_ask;
        m_tready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end else if (!idle_on) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = gap_length();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sorted_integer_set regression: fail");
    $finish;
  end

  // Request stimulus and verdict.
  initial begin
    int ins_pct;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, extremes, duplicates, head removal, ignored code, full store.
    drive_request(KIND_LOOKUP, 5);
    drive_request(KIND_INSERT, 0);
    drive_request(KIND_INSERT, VAL_MAX);
    drive_request(KIND_INSERT, VAL_MIN);
    drive_request(KIND_INSERT, -1);
    drive_request(KIND_INSERT, 1);
    drive_request(KIND_INSERT, 0);
    drive_request(KIND_LOOKUP, VAL_MAX);
    drive_request(KIND_REMOVE, VAL_MIN);
    drive_request(KIND_REMOVE, 7);
    drive_request(KIND_IGNORED, 1);
    for (int i = 0; i < 12; i++) drive_request(KIND_INSERT, 1000 - 10 * i);
    drive_request(KIND_INSERT, 12345);
    drive_request(KIND_INSERT, VAL_MAX);
    wait_drained();

    // Random phases: the insert share swings so the store fills and empties.
    for (int p = 0; p < PHASES; p++) begin
      refill_pool();
      sender_idles = (p != 1) && (p != 6);
      idle_on <= sender_idles;
      if (p == 3) squeeze_ask <= squeeze_ask + 1;
      ins_pct = (p % 3 == 0) ? 65 : (p % 3 == 1) ? 40 : 22;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        drive_request(pick_kind(ins_pct), pick_value());
        sender_gap();
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("sorted_integer_set regression: pass");
    end else begin
      $display("sorted_integer_set regression: fail");
    end
    $finish;
  end

endmodule
